/* rtl/core/irm_pkg.sv */
// ----------------------------------------------------------------------------
// irm_pkg: shared constants for the item rate meter
// Field widths, register indexes, reset values and sequencer step counts.
// ----------------------------------------------------------------------------
package irm_pkg;

  localparam int ITEM_W      = 16;
  localparam int TICK_W      = 32;
  localparam int RATE_BITS   = 40;
  localparam int ALPHA_W     = 17;
  localparam int ALPHA_SHIFT = 16;
  localparam int CNT_W       = 6;
  localparam int CFG_IDX_W   = 2;

  localparam int COUNT_WIDTH_DEF = 40;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  localparam logic [TICK_W-1:0]  WINDOW_RST = 32'd500000;
  localparam logic [TICK_W-1:0]  TPS_RST    = 32'd1000000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 17'd6554;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TPS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd2;

  // Last step index of each iterative phase
  localparam logic [CNT_W-1:0] MUL_LAST = 6'd31;
  localparam logic [CNT_W-1:0] DIV_LAST = 6'd39;
  localparam logic [CNT_W-1:0] EMA_LAST = 6'd16;

endpackage

/* rtl/core/irm_addsub.sv */
// ----------------------------------------------------------------------------
// irm_addsub: shared adder/subtractor
// One two's-complement add or subtract per cycle for the rate sequencer.
// ----------------------------------------------------------------------------
module irm_addsub #(
  parameter int W = 80
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum
);

  logic [W-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign sum  = a + b_op + W'(sub);

endmodule

/* rtl/core/item_rate_meter_ema.sv */
// ----------------------------------------------------------------------------
// item_rate_meter_ema: throughput meter with exponential moving average
// An item that does not close the window only updates the totals. One that
// closes it runs 32 multiply, 40 divide and 17 averaging steps (none while
// the average is zero) through one shared adder, plus setup and any wait for
// a held result. One item at a time; the result register lets the next item in.
// Synchronous reset clears totals, average, output valid and loads defaults.
// ----------------------------------------------------------------------------
module item_rate_meter_ema #(
  parameter int COUNT_WIDTH = irm_pkg::COUNT_WIDTH_DEF,
  parameter int FRAC_BITS   = irm_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [2*irm_pkg::ITEM_W-1:0]    s_tdata,   // batch_items, ticks_since_last
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [2*irm_pkg::RATE_BITS-1:0] m_tdata,   // cur_rate, mean_rate
  input  logic                            cfg_we,
  input  logic [irm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [irm_pkg::TICK_W-1:0]      cfg_data
);

  localparam int PW    = COUNT_WIDTH + irm_pkg::TICK_W;
  localparam int AVW   = irm_pkg::RATE_BITS + FRAC_BITS;
  localparam int EMA_W = AVW + 1 + irm_pkg::ALPHA_W;
  localparam int AW    = ((PW > EMA_W) ? PW : EMA_W) + 1;
  localparam int TW    = irm_pkg::TICK_W;
  localparam int RB    = irm_pkg::RATE_BITS;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_SAT   = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_DIFF  = 9'b000100000,
    S_EMA   = 9'b001000000,
    S_ADD   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  logic [TW-1:0]                 window_ticks;
  logic [TW-1:0]                 ticks_per_second;
  logic [irm_pkg::ALPHA_W-1:0]   alpha_q16;

  logic [COUNT_WIDTH-1:0]        count_total;
  logic [TW-1:0]                 elapsed_total;
  logic [AVW-1:0]                average_fixed;

  logic [AW-1:0]                 acc;
  logic [TW-1:0]                 mshift;
  logic [TW-1:0]                 rem;
  logic [RB-1:0]                 quot;
  logic                          sat;
  logic [RB-1:0]                 rate;
  logic signed [AVW:0]           diff;
  logic [irm_pkg::CNT_W-1:0]     cnt;

  logic [irm_pkg::ITEM_W-1:0]    batch_items;
  logic [irm_pkg::ITEM_W-1:0]    ticks_since_last;
  logic [COUNT_WIDTH:0]          count_sum;
  logic [TW:0]                   elapsed_sum;
  logic [COUNT_WIDTH-1:0]        count_next;
  logic [TW-1:0]                 elapsed_next;
  logic [TW-1:0]                 win_eff;
  logic [irm_pkg::ALPHA_W-1:0]   alpha_eff;
  logic [AW-1:0]                 upper;
  logic [TW:0]                   rem_shift;
  logic [RB-1:0]                 rate_sel;
  logic [AVW-1:0]                rfix;
  logic signed [AW-1:0]          ema_shift;

  logic [AW-1:0]                 add_a;
  logic [AW-1:0]                 add_b;
  logic                          add_sub;
  logic [AW-1:0]                 add_sum;

  assign batch_items      = s_tdata[irm_pkg::ITEM_W-1:0];
  assign ticks_since_last = s_tdata[2*irm_pkg::ITEM_W-1:irm_pkg::ITEM_W];

  assign count_sum    = {1'b0, count_total} + (COUNT_WIDTH+1)'(batch_items);
  assign elapsed_sum  = {1'b0, elapsed_total} + (TW+1)'(ticks_since_last);
  assign count_next   = count_sum[COUNT_WIDTH] ? '1 : count_sum[COUNT_WIDTH-1:0];
  assign elapsed_next = elapsed_sum[TW] ? '1 : elapsed_sum[TW-1:0];

  assign win_eff   = (window_ticks == '0) ? TW'(1) : window_ticks;
  assign alpha_eff = (alpha_q16 > irm_pkg::ALPHA_ONE) ? irm_pkg::ALPHA_ONE : alpha_q16;

  assign upper     = acc >> RB;
  assign rem_shift = {rem, quot[RB-1]};
  assign rate_sel  = sat ? '1 : quot;
  assign rfix      = {rate_sel, {FRAC_BITS{1'b0}}};
  assign ema_shift = $signed(acc) >>> irm_pkg::ALPHA_SHIFT;

  assign s_tready = (state == S_IDLE);

  irm_addsub #(
    .W (AW)
  ) u_addsub (
    .a   (add_a),
    .b   (add_b),
    .sub (add_sub),
    .sum (add_sum)
  );

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state)
      S_MUL: begin
        add_a = {acc[AW-2:0], 1'b0};
        add_b = mshift[TW-1] ? AW'(count_total) : '0;
      end
      S_SAT: begin
        add_a   = upper;
        add_b   = AW'(elapsed_total);
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_a   = AW'(rem_shift);
        add_b   = AW'(elapsed_total);
        add_sub = 1'b1;
      end
      S_DIFF: begin
        add_a   = AW'(rfix);
        add_b   = AW'(average_fixed);
        add_sub = 1'b1;
      end
      S_EMA: begin
        add_a = {acc[AW-2:0], 1'b0};
        add_b = mshift[TW-1] ? AW'(diff) : '0;
      end
      S_ADD: begin
        add_a = AW'(average_fixed);
        add_b = ema_shift;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      window_ticks     <= irm_pkg::WINDOW_RST;
      ticks_per_second <= irm_pkg::TPS_RST;
      alpha_q16        <= irm_pkg::ALPHA_RST;
      count_total      <= '0;
      elapsed_total    <= '0;
      average_fixed    <= '0;
      m_tvalid         <= 1'b0;
      cnt              <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          irm_pkg::REG_WINDOW: window_ticks     <= cfg_data;
          irm_pkg::REG_TPS:    ticks_per_second <= cfg_data;
          irm_pkg::REG_ALPHA:  alpha_q16        <= cfg_data[irm_pkg::ALPHA_W-1:0];
          default: ;
        endcase
      end

      if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            count_total   <= count_next;
            elapsed_total <= elapsed_next;
            state         <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (elapsed_total >= win_eff) begin
            acc    <= '0;
            mshift <= ticks_per_second;
            cnt    <= '0;
            state  <= S_MUL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          acc    <= add_sum;
          mshift <= {mshift[TW-2:0], 1'b0};
          cnt    <= cnt + 1'b1;
          if (cnt == irm_pkg::MUL_LAST) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          sat   <= ~add_sum[AW-1];
          rem   <= upper[TW-1:0];
          quot  <= acc[RB-1:0];
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= add_sum[AW-1] ? rem_shift[TW-1:0] : add_sum[TW-1:0];
          quot <= {quot[RB-2:0], ~add_sum[AW-1]};
          cnt  <= cnt + 1'b1;
          if (cnt == irm_pkg::DIV_LAST) begin
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          rate <= rate_sel;
          if (average_fixed == '0) begin
            average_fixed <= rfix;
            state         <= S_DONE;
          end else begin
            diff   <= add_sum[AVW:0];
            acc    <= '0;
            mshift <= {alpha_eff, {(TW-irm_pkg::ALPHA_W){1'b0}}};
            cnt    <= '0;
            state  <= S_EMA;
          end
        end
        S_EMA: begin
          acc    <= add_sum;
          mshift <= {mshift[TW-2:0], 1'b0};
          cnt    <= cnt + 1'b1;
          if (cnt == irm_pkg::EMA_LAST) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          average_fixed <= add_sum[AVW-1:0];
          state         <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata       <= {average_fixed[AVW-1:FRAC_BITS], rate};
            count_total   <= '0;
            elapsed_total <= '0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
